### sv/sgm_pkg.sv
// Shared types, constants and helper functions for the Sobel magnitude core.
// No dependencies.
package sgm_pkg;

  localparam int MaxWidth  = 2048;
  localparam int MaxHeight = 4096;
  localparam int ColW      = $clog2(MaxWidth);      // 11
  localparam int RowW      = $clog2(MaxHeight + 1); // 13
  localparam int MagW      = 11;
  localparam int RadW      = 21;                    // 2 * 1020^2 < 2^21

  localparam logic [0:0] RegWidth  = 1'b0;
  localparam logic [0:0] RegHeight = 1'b1;

  typedef enum logic [2:0] {S_IDLE, S_READ, S_CALC, S_ROOT, S_PAIR} state_t;

  typedef logic [7:0] pix_t;
  typedef struct packed {
    pix_t t;
    pix_t m;
    pix_t b;
  } triple_t;

  // Result beat as it leaves the core.
  typedef struct packed {
    logic [MagW-1:0] magnitude;
    logic            row_end;
    logic            frame_end;
    logic            last;
  } result_t;

  // a + 2b + c, at most 1020.
  function automatic logic [9:0] col_weight(pix_t a, pix_t b, pix_t c);
    return 10'(a) + {1'b0, b, 1'b0} + 10'(c);
  endfunction

  function automatic logic [9:0] abs_diff(logic [9:0] a, logic [9:0] b);
    return (a >= b) ? a - b : b - a;
  endfunction

endpackage

### sv/sgm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module sgm_ram #(
  parameter int Width = 8,
  parameter int Depth = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule

### sv/sgm_isqrt.sv
// Bit-serial integer square root (restoring, two bits of radicand per cycle).
// Depends on sgm_pkg.
module sgm_isqrt (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [sgm_pkg::RadW-1:0] radicand,
  output logic                     busy,
  output logic                     valid,
  output logic [sgm_pkg::MagW-1:0] root
);
  import sgm_pkg::*;

  logic [RadW:0] rem;
  logic [RadW:0] res;
  logic [RadW:0] bitv;
  logic [RadW:0] trial;

  assign trial = res + bitv;
  assign root  = res[MagW-1:0];

  // 11 iterations, bit 20 down to bit 0; valid holds until the next start.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      valid <= 1'b0;
    end else begin
      if (start) begin
        busy  <= 1'b1;
        valid <= 1'b0;
        rem   <= {1'b0, radicand};
        res   <= '0;
        bitv  <= {2'b01, {(RadW-1){1'b0}}};
      end else if (busy) begin
        if (rem >= trial) begin
          rem <= rem - trial;
          res <= (res >> 1) + bitv;
        end else begin
          res <= res >> 1;
        end
        bitv <= bitv >> 2;
        if (bitv[0]) begin
          busy  <= 1'b0;
          valid <= 1'b1;
        end
      end
    end
  end
endmodule

### sv/sobel_gradient_magnitude_core.sv
// Top level of the streaming 3x3 Sobel gradient magnitude core.
// Depends on sgm_pkg, sgm_ram and sgm_isqrt.
//
// Usage: pixels enter on the s_axis group in raster order, tdata = pixel,
// tuser = flush. After the last image row the source sends one row of
// flush beats; the flush row ends the frame. Results leave on m_axis with
// tdata = magnitude and tuser = {frame_end, row_end}, tlast = last result
// of the input beat. The first image row gives no results; the first
// column of each row gives none; the last column gives two beats.
// Image size is set through the cfg channel (index 0 width, 1 height);
// cfg_ready is high only while the core is idle, and a pending cfg write
// holds off s_axis_tready so both never land on the same edge.
// Timing: one beat at a time. Accept, line store read (READ), squares
// (CALC), then the bit-serial square root (ROOT). A stray flush beat is
// dropped in IDLE, a beat without results goes back to IDLE after CALC,
// and a last-column beat adds PAIR after ROOT (its mirrored result is
// |gy|, no root needed).
// Reset clears counters, window and output; line stores hold garbage.
// A stalled receiver holds the output register; the core waits in ROOT or
// PAIR until the register frees up, and only then takes the next pixel.
module sobel_gradient_magnitude_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] pixel
  input  logic        s_axis_tuser,   // [0] flush
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [10:0] magnitude, rest zero
  output logic [1:0]  m_axis_tuser,   // [0] row_end, [1] frame_end
  output logic        m_axis_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [12:0] cfg_data
);
  import sgm_pkg::*;

  state_t state, state_next;
  logic [11:0] image_width;
  logic [12:0] image_height;
  logic [11:0] w_eff;
  logic [12:0] h_eff;
  logic [ColW-1:0] column_count;
  logic [RowW-1:0] row_count;
  logic [ColW-1:0] c_cur;
  logic [RowW-1:0] r_cur;
  logic flush_row, row_last, has_res, accept, drop;
  logic line_we, sq_start, out_load, out_free;
  pix_t pix_q;
  pix_t old_rd, new_rd;
  triple_t cur, left, win0, win1;
  logic [9:0] gx_abs, gy_abs, pair_abs;
  logic two_q, flush_q, has_q;
  logic [19:0] sqx, sqy;
  logic [RadW-1:0] radicand;
  logic sq_busy, sq_valid;
  logic [MagW-1:0] sq_root;
  result_t res_q, res_next;
  logic out_full;

  assign w_eff = (image_width < 12'd2) ? 12'd2 :
                 (image_width > 12'(MaxWidth)) ? 12'(MaxWidth) : image_width;
  assign h_eff = (image_height < 13'd2) ? 13'd2 :
                 (image_height > 13'(MaxHeight)) ? 13'(MaxHeight) : image_height;
  // Counters past the current size clamp to last column / flush row.
  assign r_cur = (row_count > h_eff) ? h_eff : row_count;
  assign c_cur = ({1'b0, column_count} >= w_eff) ? ColW'(w_eff - 12'd1) : column_count;
  assign flush_row = (r_cur == h_eff);
  assign row_last  = ({1'b0, c_cur} + 12'd1 >= w_eff);
  assign has_res   = (r_cur != '0) && (c_cur != '0);

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign drop     = accept && !flush_row && s_axis_tuser;
  assign out_free = !out_full || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= 12'd640;
      image_height <= 13'd480;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        RegWidth:  image_width  <= cfg_data[11:0];
        RegHeight: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Line stores: read at accept, read-modify-write in READ. The next read
  // of any entry comes only after the write has landed, so no forwarding.
  sgm_ram #(.Width(8), .Depth(MaxWidth)) u_older (
    .clk, .we(line_we), .waddr(c_cur), .wdata(new_rd),
    .re(accept), .raddr(c_cur), .rdata(old_rd));
  sgm_ram #(.Width(8), .Depth(MaxWidth)) u_newer (
    .clk, .we(line_we), .waddr(c_cur), .wdata(pix_q),
    .re(accept), .raddr(c_cur), .rdata(new_rd));

  // Incoming column triple; row -1 mirrors to row 1, row H to row H-2.
  always_comb begin
    if (flush_row) cur = '{t: old_rd, m: new_rd, b: old_rd};
    else cur = '{t: (r_cur == RowW'(1)) ? pix_q : old_rd, m: new_rd, b: pix_q};
  end

  // Column -1 mirrors to column 1.
  assign left = (c_cur == ColW'(1)) ? cur : win1;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (accept && !drop) state_next = S_READ;
      S_READ: state_next = S_CALC;
      S_CALC: state_next = has_q ? S_ROOT : S_IDLE;
      S_ROOT: if (out_load) state_next = two_q ? S_PAIR : S_IDLE;
      S_PAIR: if (out_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs of the state machine.
  always_comb begin
    s_axis_tready = 1'b0;
    cfg_ready     = 1'b0;
    line_we       = 1'b0;
    sq_start      = 1'b0;
    out_load      = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_axis_tready = !cfg_valid;
        cfg_ready     = 1'b1;
      end
      S_READ: line_we = !flush_row;
      S_CALC: sq_start = has_q;
      S_ROOT: out_load = sq_valid && out_free;
      S_PAIR: out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (accept) pix_q <= s_axis_tdata;
    if (state == S_READ) begin
      gx_abs <= abs_diff(col_weight(cur.t, cur.m, cur.b),
                         col_weight(left.t, left.m, left.b));
      gy_abs <= abs_diff(col_weight(left.b, win0.b, cur.b),
                         col_weight(left.t, win0.t, cur.t));
      // Mirrored last column: gx is zero, the magnitude is |gy|.
      pair_abs <= abs_diff(col_weight(win0.b, cur.b, win0.b),
                           col_weight(win0.t, cur.t, win0.t));
    end
  end

  // Window and counters advance once per beat, in READ.
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      win0    <= '0;
      win1    <= '0;
      two_q   <= 1'b0;
      flush_q <= 1'b0;
      has_q   <= 1'b0;
    end else if (state == S_READ) begin
      win1    <= win0;
      win0    <= cur;
      two_q   <= row_last && has_res;
      flush_q <= flush_row;
      has_q   <= has_res;
      if (row_last) begin
        column_count <= '0;
        row_count <= flush_row ? '0 : r_cur + RowW'(1);
      end else begin
        column_count <= c_cur + ColW'(1);
        row_count <= r_cur;
      end
    end
  end

  assign sqx      = gx_abs * gx_abs;
  assign sqy      = gy_abs * gy_abs;
  assign radicand = {1'b0, sqx} + {1'b0, sqy};

  sgm_isqrt u_root (
    .clk, .rst, .start(sq_start), .radicand, .busy(sq_busy), .valid(sq_valid),
    .root(sq_root));

  always_comb begin
    if (state == S_PAIR)
      res_next = '{magnitude: {1'b0, pair_abs}, row_end: 1'b1, frame_end: flush_q,
                   last: 1'b1};
    else
      res_next = '{magnitude: sq_root, row_end: 1'b0, frame_end: 1'b0, last: !two_q};
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
      res_q    <= '0;
    end else if (out_load) begin
      out_full <= 1'b1;
      res_q    <= res_next;
    end else if (m_axis_tready) begin
      out_full <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_full;
  assign m_axis_tdata  = {5'd0, res_q.magnitude};
  assign m_axis_tuser  = {res_q.frame_end, res_q.row_end};
  assign m_axis_tlast  = res_q.last;

  assert property (@(posedge clk) disable iff (rst) accept |-> state == S_IDLE)
    else $error("beat taken while busy");
  assert property (@(posedge clk) disable iff (rst) out_full && !m_axis_tready
    |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("held result changed");
  assert property (@(posedge clk) disable iff (rst) sq_start |-> !sq_busy)
    else $error("root started while busy");
  assert property (@(posedge clk) disable iff (rst) !(accept && cfg_valid && cfg_ready))
    else $error("config write and pixel on one edge");
endmodule

### verif/sgm_checker.sv
`timescale 1ns / 100ps
// Checker for the Sobel magnitude core: watches the pixel, config and
// result channels, predicts every result beat and compares. Uses sgm_pkg.
module sgm_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,
  input  logic        s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,
  input  logic [1:0]  m_axis_tuser,
  input  logic        m_axis_tlast,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [12:0] cfg_data,
  output int          errors,
  output int          pending
);
  import sgm_pkg::*;

  logic [11:0] width_reg;
  logic [12:0] height_reg;
  pix_t        older_row [MaxWidth];
  pix_t        newer_row [MaxWidth];
  triple_t     win_now, win_prev;
  int          col, row;
  result_t     expected_q[$];

  function automatic int floor_sqrt(int v);
    int res;
    res = 0;
    for (int b = 1 << 11; b > 0; b >>= 1)
      if ((res | b) * (res | b) <= v) res |= b;
    return res;
  endfunction

  function automatic logic [10:0] grad_mag(triple_t l, triple_t m, triple_t r);
    int gx, gy;
    gx = (int'(r.t) + 2 * int'(r.m) + int'(r.b)) - (int'(l.t) + 2 * int'(l.m) + int'(l.b));
    gy = (int'(l.b) + 2 * int'(m.b) + int'(r.b)) - (int'(l.t) + 2 * int'(m.t) + int'(r.t));
    return 11'(floor_sqrt(gx * gx + gy * gy));
  endfunction

  // One accepted pixel beat: queue the results it causes, then advance.
  task automatic predict_pixel(pix_t pix, logic flush);
    int w, h, c, r;
    logic flush_row, row_last;
    triple_t cur, left;
    w = (width_reg < 2) ? 2 : (width_reg > MaxWidth) ? MaxWidth : int'(width_reg);
    h = (height_reg < 2) ? 2 : (height_reg > MaxHeight) ? MaxHeight : int'(height_reg);
    c = (col >= w) ? w - 1 : col;
    r = (row > h) ? h : row;
    flush_row = (r == h);
    if (!flush_row && flush) return;   // stray flush inside the image
    if (flush_row) begin
      cur = '{t: older_row[c], m: newer_row[c], b: older_row[c]};
    end else begin
      cur = '{t: (r == 1) ? pix : older_row[c], m: newer_row[c], b: pix};
    end
    if (r >= 1 && c >= 1) begin
      left = (c == 1) ? cur : win_prev;   // mirrored left border
      row_last = (c + 1 >= w);
      expected_q.push_back('{grad_mag(left, win_now, cur), 1'b0, 1'b0, !row_last});
      if (row_last)
        expected_q.push_back('{grad_mag(win_now, cur, win_now), 1'b1, flush_row, 1'b1});
    end
    win_prev = win_now;
    win_now  = cur;
    if (!flush_row) begin
      older_row[c] = newer_row[c];
      newer_row[c] = pix;
    end
    if (c + 1 >= w) begin
      col = 0;
      row = flush_row ? 0 : r + 1;
    end else begin
      col = c + 1;
      row = r;
    end
  endtask

  task automatic report(string what, int got, int want);
    $display("%0t: %s mismatch: got %0d, expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    result_t exp_beat;
    if (rst) begin
      width_reg  = 12'd640;
      height_reg = 13'd480;
      win_now    = '0;
      win_prev   = '0;
      col        = 0;
      row        = 0;
      errors     = 0;
      expected_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == RegWidth) width_reg = cfg_data[11:0];
        else height_reg = cfg_data;
      end
      if (s_axis_tvalid && s_axis_tready) predict_pixel(s_axis_tdata, s_axis_tuser);
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_q.size() == 0) begin
          report("unexpected result beat", m_axis_tdata, -1);
        end else begin
          exp_beat = expected_q.pop_front();
          if (m_axis_tdata != {5'b0, exp_beat.magnitude})
            report("magnitude", m_axis_tdata, exp_beat.magnitude);
          if (m_axis_tuser[0] != exp_beat.row_end)
            report("row_end", m_axis_tuser[0], exp_beat.row_end);
          if (m_axis_tuser[1] != exp_beat.frame_end)
            report("frame_end", m_axis_tuser[1], exp_beat.frame_end);
          if (m_axis_tlast != exp_beat.last)
            report("last", m_axis_tlast, exp_beat.last);
        end
      end
    end
    pending = expected_q.size();
  end
endmodule

### verif/tb.sv
`timescale 1ns / 100ps
// Testbench top for sobel_gradient_magnitude_core: drives whole frames of
// pixels and config writes. Needs sgm_pkg, the core and sgm_checker.
module tb;
  import sgm_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [0:0]  cfg_index = RegWidth;
  logic [12:0] cfg_data = '0;
  int          errors, pending;
  int          idle_pct = 0, stall_pct = 0, pixels_sent = 0;
  logic        pix_rdy, cfg_rdy;   // ready as it stands before the next edge

  always #5 clk = ~clk;

  sobel_gradient_magnitude_core DUT (.*);
  sgm_checker u_checker (.*);

  always @(negedge clk) begin
    pix_rdy = s_axis_tready;
    cfg_rdy = cfg_ready;
  end

  always @(posedge clk) m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);

  // Stop sending, wait for the results to drain, then give zero-result
  // beats time to finish.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_size(logic [12:0] w, logic [12:0] h);
    cfg_valid <= 1'b1;
    cfg_index <= RegWidth;
    cfg_data  <= w;
    @(posedge clk);
    while (!cfg_rdy) @(posedge clk);
    cfg_index <= RegHeight;
    cfg_data  <= h;
    @(posedge clk);
    while (!cfg_rdy) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_beat(logic [7:0] pix, logic flush);
    if ($urandom_range(0, 99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pix;
    s_axis_tuser  <= flush;
    @(posedge clk);
    while (!pix_rdy) @(posedge clk);
    pixels_sent++;
  endtask

  function automatic logic [7:0] rand_pixel();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // Image rows from first_row up to h-1, with a few stray flush beats,
  // then, if with_flush_row is set, the flush row (its flush bit random: it is treated as flush anyway).
  task automatic send_rows(int w, int h, int first_row, bit with_flush_row);
    for (int r = first_row; r < h; r++)
      for (int c = 0; c < w; c++) begin
        if ($urandom_range(0, 99) < 3) send_beat(8'($urandom), 1'b1);
        send_beat(rand_pixel(), 1'b0);
      end
    if (with_flush_row)
      for (int c = 0; c < w; c++) send_beat(8'($urandom), 1'($urandom));
  endtask

  task automatic random_phase(int idle, int stall, int budget);
    int w, h, target;
    idle_pct  = idle;
    stall_pct = stall;
    target = pixels_sent + budget;
    while (pixels_sent < target) begin
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(2, 12);
      h = $urandom_range(2, 6);
      drain();
      set_size(13'(w), 13'(h));
      send_rows(w, h, 0, 1'b1);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: a checkerboard, then a bright row above dark rows, on a 3x3 image.
    set_size(13'd3, 13'd3);
    for (int i = 0; i < 9; i++) send_beat((i % 2) ? 8'hFF : 8'h00, 1'b0);
    send_beat(8'hA5, 1'b1);   // flush row
    send_beat(8'h00, 1'b0);   // flush row beat with the flush bit low
    send_beat(8'hFF, 1'b1);
    send_beat(8'h5A, 1'b1);   // stray flush in the next frame's first row: ignored
    for (int i = 0; i < 3; i++) send_beat(8'hFF, 1'b0);
    for (int i = 0; i < 6; i++) send_beat(8'h00, 1'b0);
    for (int i = 0; i < 3; i++) send_beat(8'h5A, 1'b1);
    drain();
    // Smallest image.
    set_size(13'd2, 13'd2);
    send_rows(2, 2, 0, 1'b1);
    drain();
    // Height lowered mid-frame while idle: row two becomes the flush row.
    set_size(13'd4, 13'd5);
    send_rows(4, 2, 0, 1'b0);
    drain();
    set_size(13'd4, 13'd2);
    send_rows(4, 2, 2, 1'b1);
    drain();
    // Register extremes: out-of-range values clamp to the limits.
    set_size(13'd0, 13'd0);
    send_rows(2, 2, 0, 1'b1);
    drain();
    set_size(13'h1FFF, 13'h1FFF);
    for (int i = 0; i < 5; i++) send_beat(rand_pixel(), 1'b0);
    drain();
    // Width lowered mid-row: the column past the new width is the last one.
    set_size(13'd5, 13'd2);
    send_beat(rand_pixel(), 1'b0);
    send_rows(5, 2, 1, 1'b1);

    random_phase(0, 0, 360);
    random_phase(85, 0, 360);
    random_phase(0, 85, 360);
    random_phase(26, 26, 360);
    drain();

    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #(20_000_000);
    $display("Mismatches found");
    $finish;
  end
endmodule
